>>> design/vsm_pkg.sv
// Shared constants, codes and control structs of the version slot manager.
package vsm_pkg;

   // Built geometry defaults.
   localparam int SLOTS_DEFAULT         = 16;
   localparam int VERSION_WIDTH_DEFAULT = 32;

   // Smallest number of managed slots, whatever the register holds.
   localparam int MIN_SLOTS = 2;

   // Register reset value and live count ceiling.
   localparam logic [4:0] SLOTS_IN_USE_RESET = 5'd16;
   localparam logic [4:0] LIVE_MAX           = 5'd31;

   // Request actions.
   typedef enum logic [2:0] {
      ACT_CREATE      = 3'd0,
      ACT_FREEZE      = 3'd1,
      ACT_DROP        = 3'd2,
      ACT_DROP_OLDEST = 3'd3,
      ACT_FIND_LATEST = 3'd4
   } action_type;

   // Response status codes.
   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_RANGE        = 3'd1,
      ST_IMMUTABLE    = 3'd2,
      ST_NO_CANDIDATE = 3'd3,
      ST_NOT_NEWEST   = 3'd4
   } status_type;

   // Control of the slot scan unit.
   typedef struct packed {
      logic       clear;
      logic       sample;
      action_type mode;
   } scan_ctrl_type;

   // Summary flags of a finished scan.
   typedef struct packed {
      logic found;
      logic bad;
      logic two_cand;
   } scan_flags_type;

   // Control of the slot store write port.
   typedef struct packed {
      logic en;
      logic version_en;
      logic writable;
   } wr_ctrl_type;

endpackage

>>> design/vsm_slot_store.sv
// Slot metadata store: version memory with fill bits and the writable flags.
module vsm_slot_store #(
   parameter int SLOTS         = vsm_pkg::SLOTS_DEFAULT,
   parameter int VERSION_WIDTH = vsm_pkg::VERSION_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [$clog2(SLOTS)-1:0]    rd_addr,
   output logic [VERSION_WIDTH-1:0]    rd_version,
   output logic                        rd_writable,
   input  vsm_pkg::wr_ctrl_type        wr_ctrl,
   input  logic [$clog2(SLOTS)-1:0]    wr_addr,
   input  logic [VERSION_WIDTH-1:0]    wr_version
);

   logic [VERSION_WIDTH-1:0] mem [SLOTS];
   logic [SLOTS-1:0]         filled_ff;
   logic [SLOTS-1:0]         writable_ff;
   logic [VERSION_WIDTH-1:0] rd_raw_ff;
   logic                     rd_filled_ff;
   logic                     rd_writable_ff;

   // Version memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_ctrl.en && wr_ctrl.version_en) begin
         mem[wr_addr] <= wr_version;
      end
      rd_raw_ff      <= mem[rd_addr];
      rd_filled_ff   <= filled_ff[rd_addr];
      rd_writable_ff <= writable_ff[rd_addr];
   end

   // Fill bits and writable flags are cleared at once by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff   <= '0;
         writable_ff <= '0;
      end else if (wr_ctrl.en) begin
         writable_ff[wr_addr] <= wr_ctrl.writable;
         if (wr_ctrl.version_en) begin
            filled_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // An entry never written reads as an empty slot.
   assign rd_version  = rd_filled_ff ? rd_raw_ff : '0;
   assign rd_writable = rd_writable_ff;

endmodule

>>> design/vsm_scan_unit.sv
// Shared compare unit that folds one slot per cycle into the scan summary.
module vsm_scan_unit #(
   parameter int SLOTS         = vsm_pkg::SLOTS_DEFAULT,
   parameter int VERSION_WIDTH = vsm_pkg::VERSION_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vsm_pkg::scan_ctrl_type      ctrl,
   input  logic [$clog2(SLOTS)-1:0]    sample_idx,
   input  logic [VERSION_WIDTH-1:0]    sample_version,
   input  logic                        sample_writable,
   input  logic [VERSION_WIDTH-1:0]    counter,
   output logic [$clog2(SLOTS)-1:0]    max_pos,
   output logic [VERSION_WIDTH-1:0]    max_val,
   output logic [$clog2(SLOTS)-1:0]    min_pos,
   output logic [VERSION_WIDTH-1:0]    min_val,
   output vsm_pkg::scan_flags_type     flags
);

   localparam int AW = $clog2(SLOTS);

   logic [AW-1:0]            max_pos_ff;
   logic [VERSION_WIDTH-1:0] max_val_ff;
   logic [AW-1:0]            min_pos_ff;
   logic [VERSION_WIDTH-1:0] min_val_ff;
   logic                     found_ff;
   logic                     found_in;
   logic                     bad_ff;
   logic                     bad_in;
   logic [1:0]               cnt_ff;
   logic [1:0]               cnt_in;
   logic                     cand;
   logic                     min_hit;
   logic                     take_max;
   logic                     take_min;

   // Candidate selection and the three version compares.
   always_comb begin
      if (ctrl.mode == vsm_pkg::ACT_CREATE) begin
         cand    = 1'b1;
         min_hit = sample_version < min_val_ff;
      end else begin
         cand    = (sample_version != '0) && !sample_writable;
         min_hit = sample_version <= min_val_ff;
      end
      take_max = cand && (!found_ff || (sample_version > max_val_ff));
      take_min = cand && (!found_ff || min_hit);
   end

   // Next summary flags.
   always_comb begin
      found_in = found_ff;
      bad_in   = bad_ff;
      cnt_in   = cnt_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
         bad_in   = 1'b0;
         cnt_in   = '0;
      end else if (ctrl.sample) begin
         if (cand) begin
            found_in = 1'b1;
            if (!cnt_ff[1]) begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         if ((ctrl.mode == vsm_pkg::ACT_CREATE) && (counter <= sample_version)) begin
            bad_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         bad_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         found_ff <= found_in;
         bad_ff   <= bad_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Running newest and oldest positions with their versions.
   always_ff @(posedge clock) begin
      if (!ctrl.clear && ctrl.sample && !bad_ff) begin
         if (take_max) begin
            max_pos_ff <= sample_idx;
            max_val_ff <= sample_version;
         end
         if (take_min) begin
            min_pos_ff <= sample_idx;
            min_val_ff <= sample_version;
         end
      end
   end

   assign max_pos        = max_pos_ff;
   assign max_val        = max_val_ff;
   assign min_pos        = min_pos_ff;
   assign min_val        = min_val_ff;
   assign flags.found    = found_ff;
   assign flags.bad      = bad_ff;
   assign flags.two_cand = cnt_ff[1];

endmodule

>>> design/version_slot_manager_unit.sv
// Version slot manager: a sequencer over the slot store and the shared scan unit.
// From request transfer to response valid: create runs scan, drain, decide, write-new and finish
// (write-new is skipped when a slot is not older than the new version), drop-oldest and
// find-latest run scan, drain, decide and finish, freeze and drop run check and finish, range
// errors and unknown actions go straight to finish; the scan reads one managed slot per cycle.
// A new request is taken only once the response is registered. Synchronous reset clears state.
module version_slot_manager_unit #(
   parameter int SLOTS         = vsm_pkg::SLOTS_DEFAULT,
   parameter int VERSION_WIDTH = vsm_pkg::VERSION_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_slots_in_use,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_slot_index,
   input  logic        req_protect_frozen,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_result_slot,
   output logic [31:0] rsp_result_version,
   output logic        rsp_fresh_value,
   output logic        rsp_copy_valid,
   output logic [3:0]  rsp_copy_source,
   output logic        rsp_evicted,
   output logic        rsp_released_value,
   output logic [4:0]  rsp_live_count
);

   localparam int AW    = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int VW    = VERSION_WIDTH;

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_SCAN      = 7'b0000010,
      S_DRAIN     = 7'b0000100,
      S_DECIDE    = 7'b0001000,
      S_WRITE_NEW = 7'b0010000,
      S_CHECK     = 7'b0100000,
      S_FINISH    = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   vsm_pkg::action_type     action_ff, action_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic                    protect_ff, protect_in;
   logic [AW-1:0]           n_last_ff, n_last_in;
   logic [AW-1:0]           scan_ff, scan_in;
   logic                    sample_ff, sample_in;
   logic [AW-1:0]           sample_idx_ff, sample_idx_in;
   logic [VW-1:0]           counter_ff, counter_in;
   logic [4:0]              live_ff, live_in;
   logic [4:0]              slots_in_use_ff;
   vsm_pkg::status_type     pend_status_ff, pend_status_in;
   logic [AW-1:0]           pend_slot_ff, pend_slot_in;
   logic [VW-1:0]           pend_version_ff, pend_version_in;
   logic                    pend_fresh_ff, pend_fresh_in;
   logic                    pend_cvalid_ff, pend_cvalid_in;
   logic [AW-1:0]           pend_csrc_ff, pend_csrc_in;
   logic                    pend_evict_ff, pend_evict_in;
   logic                    pend_rel_ff, pend_rel_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_load;
   logic [2:0]              rsp_status_ff;
   logic [3:0]              rsp_result_slot_ff;
   logic [31:0]             rsp_result_version_ff;
   logic                    rsp_fresh_value_ff;
   logic                    rsp_copy_valid_ff;
   logic [3:0]              rsp_copy_source_ff;
   logic                    rsp_evicted_ff;
   logic                    rsp_released_value_ff;
   logic [4:0]              rsp_live_count_ff;
   logic [CNT_W-1:0]        active;
   logic [AW-1:0]           rd_addr;
   logic [VW-1:0]           rd_version;
   logic                    rd_writable;
   vsm_pkg::wr_ctrl_type    wr_ctrl;
   logic [AW-1:0]           wr_addr;
   logic [VW-1:0]           wr_version;
   vsm_pkg::scan_ctrl_type  scan_ctrl;
   vsm_pkg::scan_flags_type scan_flags;
   logic [AW-1:0]           max_pos;
   logic [VW-1:0]           max_val;
   logic [AW-1:0]           min_pos;
   logic [VW-1:0]           min_val;
   logic [4:0]              live_up;
   logic [4:0]              live_down;

   vsm_slot_store #(
      .SLOTS         (SLOTS),
      .VERSION_WIDTH (VERSION_WIDTH)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_addr     (rd_addr),
      .rd_version  (rd_version),
      .rd_writable (rd_writable),
      .wr_ctrl     (wr_ctrl),
      .wr_addr     (wr_addr),
      .wr_version  (wr_version)
   );

   vsm_scan_unit #(
      .SLOTS         (SLOTS),
      .VERSION_WIDTH (VERSION_WIDTH)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (scan_ctrl),
      .sample_idx      (sample_idx_ff),
      .sample_version  (rd_version),
      .sample_writable (rd_writable),
      .counter         (counter_ff),
      .max_pos         (max_pos),
      .max_val         (max_val),
      .min_pos         (min_pos),
      .min_val         (min_val),
      .flags           (scan_flags)
   );

   // The register is clamped between the smallest slot count and the number of slots that are built.
   always_comb begin
      if (slots_in_use_ff < 5'(vsm_pkg::MIN_SLOTS)) begin
         active = CNT_W'(vsm_pkg::MIN_SLOTS);
      end else if (32'(slots_in_use_ff) > SLOTS) begin
         active = CNT_W'(SLOTS);
      end else begin
         active = CNT_W'(slots_in_use_ff);
      end
   end

   // Saturating live count steps.
   assign live_up   = (live_ff < vsm_pkg::LIVE_MAX) ? live_ff + 5'd1 : live_ff;
   assign live_down = (live_ff != 5'd0) ? live_ff - 5'd1 : live_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      action_in       = action_ff;
      idx_in          = idx_ff;
      protect_in      = protect_ff;
      n_last_in       = n_last_ff;
      scan_in         = scan_ff;
      sample_in       = 1'b0;
      sample_idx_in   = scan_ff;
      counter_in      = counter_ff;
      live_in         = live_ff;
      pend_status_in  = pend_status_ff;
      pend_slot_in    = pend_slot_ff;
      pend_version_in = pend_version_ff;
      pend_fresh_in   = pend_fresh_ff;
      pend_cvalid_in  = pend_cvalid_ff;
      pend_csrc_in    = pend_csrc_ff;
      pend_evict_in   = pend_evict_ff;
      pend_rel_in     = pend_rel_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rd_addr         = scan_ff;
      wr_ctrl         = '0;
      wr_addr         = '0;
      wr_version      = '0;
      scan_ctrl.clear  = 1'b0;
      scan_ctrl.sample = sample_ff;
      scan_ctrl.mode   = action_ff;

      case (state_ff)
         S_IDLE: begin
            // The addressed slot is read here so that freeze and drop can check it next.
            rd_addr = req_slot_index[AW-1:0];
            if (req_valid) begin
               action_in       = vsm_pkg::action_type'(req_action);
               idx_in          = req_slot_index[AW-1:0];
               protect_in      = req_protect_frozen;
               n_last_in       = AW'(active - CNT_W'(1));
               scan_in         = '0;
               scan_ctrl.clear = 1'b1;
               pend_status_in  = vsm_pkg::ST_OK;
               pend_slot_in    = '0;
               pend_version_in = '0;
               pend_fresh_in   = 1'b0;
               pend_cvalid_in  = 1'b0;
               pend_csrc_in    = '0;
               pend_evict_in   = 1'b0;
               pend_rel_in     = 1'b0;
               case (vsm_pkg::action_type'(req_action))
                  vsm_pkg::ACT_CREATE: begin
                     counter_in = counter_ff + VW'(1);
                     state_in   = S_SCAN;
                  end
                  vsm_pkg::ACT_DROP_OLDEST, vsm_pkg::ACT_FIND_LATEST: begin
                     state_in = S_SCAN;
                  end
                  vsm_pkg::ACT_FREEZE, vsm_pkg::ACT_DROP: begin
                     if (32'(req_slot_index) >= 32'(active)) begin
                        pend_status_in = vsm_pkg::ST_RANGE;
                        state_in       = S_FINISH;
                     end else begin
                        state_in = S_CHECK;
                     end
                  end
                  default: begin
                     pend_status_in = vsm_pkg::ST_NO_CANDIDATE;
                     state_in       = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // One slot read per cycle; its registered data reaches the scan unit in the following cycle.
            sample_in     = 1'b1;
            sample_idx_in = scan_ff;
            if (scan_ff == n_last_ff) begin
               state_in = S_DRAIN;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_FINISH;
            case (action_ff)
               vsm_pkg::ACT_CREATE: begin
                  if (scan_flags.bad) begin
                     pend_status_in = vsm_pkg::ST_NOT_NEWEST;
                  end else begin
                     pend_slot_in    = min_pos;
                     pend_version_in = counter_ff;
                     state_in        = S_WRITE_NEW;
                     if (max_val != '0) begin
                        // Freeze the newest version before the new one is written.
                        wr_ctrl.en     = 1'b1;
                        wr_addr        = max_pos;
                        pend_cvalid_in = 1'b1;
                        pend_csrc_in   = max_pos;
                        if (min_val == '0) begin
                           pend_fresh_in = 1'b1;
                           live_in       = live_up;
                        end else begin
                           pend_evict_in = 1'b1;
                        end
                     end else begin
                        pend_fresh_in = 1'b1;
                        live_in       = live_up;
                     end
                  end
               end
               vsm_pkg::ACT_DROP_OLDEST: begin
                  if (scan_flags.two_cand) begin
                     wr_ctrl.en         = 1'b1;
                     wr_ctrl.version_en = 1'b1;
                     wr_addr            = min_pos;
                     pend_slot_in       = min_pos;
                     if (min_val != '0) begin
                        pend_rel_in = 1'b1;
                        live_in     = live_down;
                     end
                  end else begin
                     pend_status_in = vsm_pkg::ST_NO_CANDIDATE;
                  end
               end
               vsm_pkg::ACT_FIND_LATEST: begin
                  if (scan_flags.found) begin
                     pend_slot_in    = max_pos;
                     pend_version_in = max_val;
                  end else begin
                     pend_status_in = vsm_pkg::ST_NO_CANDIDATE;
                  end
               end
               default: begin
                  pend_status_in = vsm_pkg::ST_NO_CANDIDATE;
               end
            endcase
         end
         S_WRITE_NEW: begin
            wr_ctrl.en         = 1'b1;
            wr_ctrl.version_en = 1'b1;
            wr_ctrl.writable   = 1'b1;
            wr_addr            = pend_slot_ff;
            wr_version         = counter_ff;
            state_in           = S_FINISH;
         end
         S_CHECK: begin
            // The addressed slot's version and flag are valid now.
            state_in = S_FINISH;
            case (action_ff)
               vsm_pkg::ACT_FREEZE: begin
                  if (!rd_writable) begin
                     pend_status_in = vsm_pkg::ST_IMMUTABLE;
                  end else begin
                     wr_ctrl.en      = 1'b1;
                     wr_addr         = idx_ff;
                     pend_slot_in    = idx_ff;
                     pend_version_in = rd_version;
                  end
               end
               vsm_pkg::ACT_DROP: begin
                  if (protect_ff && !rd_writable) begin
                     pend_status_in = vsm_pkg::ST_IMMUTABLE;
                  end else begin
                     wr_ctrl.en         = 1'b1;
                     wr_ctrl.version_en = 1'b1;
                     wr_addr            = idx_ff;
                     pend_slot_in       = idx_ff;
                     if (rd_version != '0) begin
                        pend_rel_in = 1'b1;
                        live_in     = live_down;
                     end
                  end
               end
               default: begin
                  pend_status_in = vsm_pkg::ST_NO_CANDIDATE;
               end
            endcase
         end
         S_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         sample_ff       <= 1'b0;
         counter_ff      <= '0;
         live_ff         <= '0;
         slots_in_use_ff <= vsm_pkg::SLOTS_IN_USE_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sample_ff    <= sample_in;
         counter_ff   <= counter_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            slots_in_use_ff <= csr_slots_in_use;
         end
      end
   end

   // Request fields, scan position and pending result.
   always_ff @(posedge clock) begin
      action_ff       <= action_in;
      idx_ff          <= idx_in;
      protect_ff      <= protect_in;
      n_last_ff       <= n_last_in;
      scan_ff         <= scan_in;
      sample_idx_ff   <= sample_idx_in;
      pend_status_ff  <= pend_status_in;
      pend_slot_ff    <= pend_slot_in;
      pend_version_ff <= pend_version_in;
      pend_fresh_ff   <= pend_fresh_in;
      pend_cvalid_ff  <= pend_cvalid_in;
      pend_csrc_ff    <= pend_csrc_in;
      pend_evict_ff   <= pend_evict_in;
      pend_rel_ff     <= pend_rel_in;
   end

   // Response register: loaded when the output side is free.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff         <= pend_status_ff;
         rsp_result_slot_ff    <= 4'(pend_slot_ff);
         rsp_result_version_ff <= 32'(pend_version_ff);
         rsp_fresh_value_ff    <= pend_fresh_ff;
         rsp_copy_valid_ff     <= pend_cvalid_ff;
         rsp_copy_source_ff    <= 4'(pend_csrc_ff);
         rsp_evicted_ff        <= pend_evict_ff;
         rsp_released_value_ff <= pend_rel_ff;
         rsp_live_count_ff     <= live_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_slot    = rsp_result_slot_ff;
   assign rsp_result_version = rsp_result_version_ff;
   assign rsp_fresh_value    = rsp_fresh_value_ff;
   assign rsp_copy_valid     = rsp_copy_valid_ff;
   assign rsp_copy_source    = rsp_copy_source_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_released_value = rsp_released_value_ff;
   assign rsp_live_count     = rsp_live_count_ff;

`ifndef SYNTHESIS
   // A request transfer always starts work on it.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("request transfer did not leave idle");

   // The scan never runs past the last managed slot.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> scan_ff <= n_last_ff)
      else $error("scan position beyond the managed slots");

   // A refused action reports no slot data.
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != vsm_pkg::ST_OK) |->
         (rsp_result_slot_ff == 4'd0) && (rsp_result_version_ff == 32'd0) &&
         !rsp_fresh_value_ff && !rsp_copy_valid_ff && (rsp_copy_source_ff == 4'd0) &&
         !rsp_evicted_ff && !rsp_released_value_ff)
      else $error("error response carries slot data");

   // A copying create either fills an empty slot or evicts, and never releases.
   a_copy_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_copy_valid_ff |->
         (rsp_fresh_value_ff || rsp_evicted_ff) && !rsp_released_value_ff)
      else $error("inconsistent create response");

   // The live count can never exceed the built slots.
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      32'(live_ff) <= SLOTS)
      else $error("live count exceeds built slots");
`endif

endmodule

>>> tb/version_slot_manager_unit_tb.sv
// Self-checking testbench of the version slot manager, with its own slot store predictor.
module version_slot_manager_unit_tb;

   localparam int N_SLOTS          = vsm_pkg::SLOTS_DEFAULT;
   localparam int ACTION_CODES     = 8;
   localparam int MIN_FROZEN_DROP  = 2;
   localparam int LONG_HOLD        = 400;
   localparam int TAIL_CYCLES      = 40;
   localparam int PHASE_ITEMS      = 150;
   localparam int MAX_REPORTS      = 10;

   // One expected response, as the block should present it.
   typedef struct {
      vsm_pkg::status_type status;
      logic [3:0]          slot;
      logic [31:0]         version;
      logic                fresh;
      logic                copy_valid;
      logic [3:0]          copy_source;
      logic                evicted;
      logic                released;
      logic [4:0]          live;
   } slot_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_slots_in_use = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = '0;
   logic [7:0]  req_slot_index = '0;
   logic        req_protect_frozen = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_result_slot;
   logic [31:0] rsp_result_version;
   logic        rsp_fresh_value;
   logic        rsp_copy_valid;
   logic [3:0]  rsp_copy_source;
   logic        rsp_evicted;
   logic        rsp_released_value;
   logic [4:0]  rsp_live_count;

   // Predicted copy of the slot metadata and of the register.
   logic [31:0] slot_ver [N_SLOTS] = '{default: '0};
   logic        slot_wr  [N_SLOTS] = '{default: 1'b0};
   logic [31:0] ver_ctr  = '0;
   logic [4:0]  live_cnt = '0;
   logic [4:0]  cfg_slots = vsm_pkg::SLOTS_IN_USE_RESET;

   slot_rsp_type expected_rsps [$];
   int           fail_count = 0;

   // Idling controls shared by the stimulus and the receiver.
   bit          req_idle_on = 1'b0;
   bit          rsp_idle_on = 1'b0;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          stall_left = 0;

   version_slot_manager_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_slots_in_use   (csr_slots_in_use),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_slot_index     (req_slot_index),
      .req_protect_frozen (req_protect_frozen),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_result_slot    (rsp_result_slot),
      .rsp_result_version (rsp_result_version),
      .rsp_fresh_value    (rsp_fresh_value),
      .rsp_copy_valid     (rsp_copy_valid),
      .rsp_copy_source    (rsp_copy_source),
      .rsp_evicted        (rsp_evicted),
      .rsp_released_value (rsp_released_value),
      .rsp_live_count     (rsp_live_count)
   );

   always #1 clock = ~clock;

   // Effective number of managed slots: the register clamped to the built range.
   function automatic int managed_slots();
      int n;
      n = cfg_slots;
      if (n < vsm_pkg::MIN_SLOTS) n = vsm_pkg::MIN_SLOTS;
      if (n > N_SLOTS) n = N_SLOTS;
      return n;
   endfunction

   // Empties one slot and tells whether a live payload was released.
   function automatic logic release_slot(input int p);
      logic rel;
      rel = 1'b0;
      if (slot_ver[p] != '0) begin
         if (live_cnt != '0) live_cnt--;
         rel = 1'b1;
      end
      slot_ver[p] = '0;
      slot_wr[p] = 1'b0;
      return rel;
   endfunction

   // Applies one action to the predicted slot store and builds the expected response.
   task automatic apply_slot_action(input logic [2:0] act, input logic [7:0] idx,
                                    input logic prot, output slot_rsp_type r);
      int          n;
      int          oldest;
      int          newest;
      int          pos;
      int          cnt;
      logic        bad;
      logic        found;
      logic [31:0] minv;
      n = managed_slots();
      r.status = vsm_pkg::ST_OK;
      r.slot = '0;
      r.version = '0;
      r.fresh = 1'b0;
      r.copy_valid = 1'b0;
      r.copy_source = '0;
      r.evicted = 1'b0;
      r.released = 1'b0;
      case (act)
         vsm_pkg::ACT_CREATE: begin
            ver_ctr = ver_ctr + 32'd1;
            oldest = 0;
            newest = 0;
            bad = 1'b0;
            // The scan stops at the first slot not older than the new version.
            for (int i = 0; i < n; i++) begin
               if (!bad) begin
                  if (ver_ctr <= slot_ver[i]) begin
                     bad = 1'b1;
                  end else begin
                     if (slot_ver[i] > slot_ver[newest]) newest = i;
                     if (slot_ver[i] < slot_ver[oldest]) oldest = i;
                  end
               end
            end
            if (bad) begin
               r.status = vsm_pkg::ST_NOT_NEWEST;
            end else begin
               if (slot_ver[newest] != '0) begin
                  slot_wr[newest] = 1'b0;
                  if (slot_ver[oldest] == '0) begin
                     if (live_cnt != vsm_pkg::LIVE_MAX) live_cnt++;
                     r.fresh = 1'b1;
                  end else begin
                     r.evicted = 1'b1;
                  end
                  r.copy_valid = 1'b1;
                  r.copy_source = 4'(newest);
               end else begin
                  if (live_cnt != vsm_pkg::LIVE_MAX) live_cnt++;
                  r.fresh = 1'b1;
               end
               slot_ver[oldest] = ver_ctr;
               slot_wr[oldest] = 1'b1;
               r.slot = 4'(oldest);
               r.version = ver_ctr;
            end
         end
         vsm_pkg::ACT_FREEZE: begin
            if (idx >= n) begin
               r.status = vsm_pkg::ST_RANGE;
            end else if (!slot_wr[idx]) begin
               r.status = vsm_pkg::ST_IMMUTABLE;
            end else begin
               slot_wr[idx] = 1'b0;
               r.slot = idx[3:0];
               r.version = slot_ver[idx];
            end
         end
         vsm_pkg::ACT_DROP: begin
            if (idx >= n) begin
               r.status = vsm_pkg::ST_RANGE;
            end else if (prot && !slot_wr[idx]) begin
               r.status = vsm_pkg::ST_IMMUTABLE;
            end else begin
               r.released = release_slot(idx);
               r.slot = idx[3:0];
            end
         end
         vsm_pkg::ACT_DROP_OLDEST: begin
            // Oldest frozen slot, the last one on equal versions.
            pos = 0;
            cnt = 0;
            minv = '1;
            for (int i = 0; i < n; i++) begin
               if (slot_ver[i] != '0 && !slot_wr[i]) begin
                  if (slot_ver[i] <= minv) begin
                     minv = slot_ver[i];
                     pos = i;
                  end
                  cnt++;
               end
            end
            if (cnt >= MIN_FROZEN_DROP) begin
               r.released = release_slot(pos);
               r.slot = 4'(pos);
            end else begin
               r.status = vsm_pkg::ST_NO_CANDIDATE;
            end
         end
         vsm_pkg::ACT_FIND_LATEST: begin
            // Newest frozen slot, the first one on equal versions.
            found = 1'b0;
            pos = 0;
            for (int i = 0; i < n; i++) begin
               if (!slot_wr[i] && slot_ver[i] != '0 &&
                   (!found || slot_ver[i] > slot_ver[pos])) begin
                  pos = i;
                  found = 1'b1;
               end
            end
            if (found) begin
               r.slot = 4'(pos);
               r.version = slot_ver[pos];
            end else begin
               r.status = vsm_pkg::ST_NO_CANDIDATE;
            end
         end
         default: begin
            r.status = vsm_pkg::ST_NO_CANDIDATE;
         end
      endcase
      r.live = live_cnt;
   endtask

   // Offers one request, waits for its transfer and records the prediction.
   // Valid is left high on return; the caller's next step either offers another
   // request or lowers it.
   task automatic send_request(input logic [2:0] act, input logic [7:0] idx, input logic prot);
      int           gap;
      slot_rsp_type r;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_slot_index <= idx;
      req_protect_frozen <= prot;
      do @(posedge clock); while (!req_ready);
      apply_slot_action(act, idx, prot, r);
      expected_rsps.push_back(r);
   endtask

   // Stops offering and waits until every predicted response has been seen.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // Writes the slot count register; only called while the block is idle.
   task automatic write_slot_count(input logic [4:0] value);
      csr_valid <= 1'b1;
      csr_slots_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      cfg_slots = value;
      csr_valid <= 1'b0;
   endtask

   // Random request, biased towards actions that keep the store busy.
   task automatic send_random_request();
      int         n;
      int         pick;
      int         k;
      int         s;
      logic [2:0] act;
      logic [7:0] idx;
      logic       prot;
      n = managed_slots();
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 19);
      if (k < 14) idx = 8'($urandom_range(0, n - 1));
      else if (k < 17) idx = 8'(n + $urandom_range(0, 3));
      else idx = 8'($urandom_range(0, 255));
      prot = 1'($urandom_range(0, 1));
      if (pick < 36) begin
         act = vsm_pkg::ACT_CREATE;
      end else if (pick < 56) begin
         act = vsm_pkg::ACT_FREEZE;
         // Mostly aim at a slot that can still be frozen.
         if ($urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, n - 1);
            for (int j = 0; j < n; j++) begin
               s = (k + j) % n;
               if (slot_wr[s]) begin
                  idx = 8'(s);
                  break;
               end
            end
         end
      end else if (pick < 72) begin
         act = vsm_pkg::ACT_DROP;
      end else if (pick < 84) begin
         act = vsm_pkg::ACT_DROP_OLDEST;
      end else if (pick < 95) begin
         act = vsm_pkg::ACT_FIND_LATEST;
      end else begin
         act = 3'($urandom_range(int'(vsm_pkg::ACT_FIND_LATEST) + 1, ACTION_CODES - 1));
      end
      send_request(act, idx, prot);
   endtask

   // Find-latest, drop-oldest, freeze and drop against the empty store after reset, plus range and unknown codes.
   task automatic test_empty_store();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_request(vsm_pkg::ACT_FIND_LATEST, 8'd0, 1'b0);
      send_request(vsm_pkg::ACT_DROP_OLDEST, 8'd0, 1'b0);
      send_request(vsm_pkg::ACT_FREEZE, 8'd0, 1'b0);
      send_request(vsm_pkg::ACT_DROP, 8'd0, 1'b1);
      send_request(vsm_pkg::ACT_DROP, 8'd0, 1'b0);
      send_request(vsm_pkg::ACT_FREEZE, 8'hFF, 1'b1);
      send_request(vsm_pkg::ACT_DROP, 8'(N_SLOTS), 1'b1);
      for (int a = int'(vsm_pkg::ACT_FIND_LATEST) + 1; a < ACTION_CODES; a++) begin
         send_request(3'(a), 8'hFF, 1'b1);
      end
   endtask

   // Creation chain, freezing, protection and dropping of the oldest frozen slot.
   task automatic test_create_and_freeze();
      send_request(vsm_pkg::ACT_CREATE, 8'd0, 1'b0);
      send_request(vsm_pkg::ACT_CREATE, 8'd0, 1'b0);
      send_request(vsm_pkg::ACT_CREATE, 8'd0, 1'b0);
      send_request(vsm_pkg::ACT_FREEZE, 8'd2, 1'b0);
      send_request(vsm_pkg::ACT_FREEZE, 8'd2, 1'b0);
      send_request(vsm_pkg::ACT_FIND_LATEST, 8'd0, 1'b0);
      send_request(vsm_pkg::ACT_DROP, 8'd1, 1'b1);
      send_request(vsm_pkg::ACT_DROP_OLDEST, 8'd0, 1'b0);
      send_request(vsm_pkg::ACT_DROP, 8'd2, 1'b0);
   endtask

   // Smallest slot count: creation must overwrite live older versions.
   task automatic test_two_slot_eviction();
      drain_responses();
      write_slot_count(5'(vsm_pkg::MIN_SLOTS));
      send_request(vsm_pkg::ACT_CREATE, 8'd0, 1'b0);
      send_request(vsm_pkg::ACT_CREATE, 8'd0, 1'b0);
      send_request(vsm_pkg::ACT_CREATE, 8'd0, 1'b0);
      send_request(vsm_pkg::ACT_FREEZE, 8'(vsm_pkg::MIN_SLOTS), 1'b0);
   endtask

   // Receiver holds off for a long stretch while requests keep coming, then the
   // sender pauses until every response has been taken.
   task automatic test_backpressure();
      drain_responses();
      write_slot_count(vsm_pkg::SLOTS_IN_USE_RESET);
      hold_requests++;
      for (int i = 0; i < 25; i++) send_random_request();
      drain_responses();
      for (int i = 0; i < 10; i++) send_random_request();
   endtask

   // Random phases over several slot counts; the last phases run without idling.
   task automatic test_random_phases();
      logic [4:0] counts [12];
      counts = '{5'd16, 5'd31, 5'd7, 5'd2, 5'd0, 5'd12, 5'd1, 5'd17, 5'd9, 5'd16, 5'd3, 5'd24};
      foreach (counts[p]) begin
         drain_responses();
         write_slot_count(counts[p]);
         req_idle_on = (p < 9) && (p % 3 != 2);
         rsp_idle_on = (p < 9) && (p % 3 != 1);
         for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();
      end
   endtask

   // Receiver: a long hold on request, otherwise short random stalls.
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         stall_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Each response transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      slot_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected response: status=%0d slot=%0d",
                        rsp_status, rsp_result_slot);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status || rsp_result_slot !== e.slot ||
                rsp_result_version !== e.version || rsp_fresh_value !== e.fresh ||
                rsp_copy_valid !== e.copy_valid || rsp_copy_source !== e.copy_source ||
                rsp_evicted !== e.evicted || rsp_released_value !== e.released ||
                rsp_live_count !== e.live) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display({"mismatch expected: st=%0d slot=%0d ver=%0h fresh=%0b",
                            " copy=%0b src=%0d evict=%0b rel=%0b live=%0d"},
                           e.status, e.slot, e.version, e.fresh, e.copy_valid,
                           e.copy_source, e.evicted, e.released, e.live);
                  $display({"         actual:   st=%0d slot=%0d ver=%0h fresh=%0b",
                            " copy=%0b src=%0d evict=%0b rel=%0b live=%0d"},
                           rsp_status, rsp_result_slot, rsp_result_version, rsp_fresh_value,
                           rsp_copy_valid, rsp_copy_source, rsp_evicted, rsp_released_value,
                           rsp_live_count);
               end
            end
         end
      end
   end

   // Test sequence.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_create_and_freeze();
      test_two_slot_eviction();
      test_backpressure();
      test_random_phases();
      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #1000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> version_slot_manager_unit.f
design/vsm_pkg.sv
design/vsm_slot_store.sv
design/vsm_scan_unit.sv
design/version_slot_manager_unit.sv
tb/version_slot_manager_unit_tb.sv
